// ===== rtl/xmbt_pkg.sv =====
// xmbt_pkg: widths, stream field layout, mode codes and controller states
// for the xor mex binary trie block.
// Depends on nothing; imported by rtl/xor_mex_binary_trie.sv.
package xmbt_pkg;

   // value width and derived tree geometry
   localparam int VALUE_BITS     = 16;
   localparam int NODE_BITS      = VALUE_BITS + 1;
   localparam int NODE_DEPTH     = 1 << NODE_BITS;
   localparam int LVL_BITS       = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((NODE_BITS + 7) / 8) * 8;

   // request kind carried in req_tuser
   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_LEAF,
      ST_INS_UP,
      ST_QRY_ROOT,
      ST_QRY_WALK,
      ST_QRY_DONE
   } xmbt_state_type;

endpackage

// ===== rtl/xor_mex_binary_trie.sv =====
// xor_mex_binary_trie: set of distinct values kept as a heap-ordered tree of
// subtree counts in one synchronous memory, plus a running xor mask.
// Depends on rtl/xmbt_pkg.sv.
//
//   channel   dir  signals                        payload (low bit up)
//   req       in   req_tvalid/tready/tdata/tuser  tdata: value; tuser: mode
//   rsp       out  rsp_tvalid/tready/tdata        tdata: mex, zero padded
//
// An item is taken only while the controller is idle; each one then runs
// through the single count memory (one read and one write port, read data
// registered). An insert does a leaf read, then one read-modify-write per
// level up to the root; a duplicate stops after the leaf read. A query does
// a root read, then one child read per level, and stops after the root read
// when the set is full. After reset a clearing pass writes zero to all
// 2^(VALUE_BITS+1) entries before the first item is taken. A finished result
// waits in the output register; inserts go on meanwhile, and a query that
// ends while it is still held waits for it to be taken.
module xor_mex_binary_trie
   import xmbt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // value
   input  logic                      req_tuser,   // mode
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata    // mex
);

   // count memory
   logic [NODE_BITS-1:0] node_mem [NODE_DEPTH];
   logic                 rd_en;
   logic [NODE_BITS-1:0] rd_addr;
   logic [NODE_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [NODE_BITS-1:0] wr_addr;
   logic [NODE_BITS-1:0] wr_data;

   // control and working registers
   xmbt_state_type       state_ff, state_in;
   logic [NODE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [LVL_BITS-1:0]  level_ff, level_in;
   logic [VALUE_BITS-1:0] ans_ff, ans_in;
   logic [VALUE_BITS-1:0] mask_ff, mask_in;
   logic [NODE_BITS-1:0] res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // shared decisions
   logic                 req_xfer;
   logic                 rsp_free;
   logic                 clr_last;
   logic                 leaf_dup;
   logic                 at_root;
   logic                 root_full;
   logic                 child_full;
   logic                 at_bottom;
   logic                 bit_cur;
   logic                 bit_next;
   logic [LVL_BITS-1:0]  level_m1;
   logic [NODE_BITS-1:0] walk_node;
   logic [VALUE_BITS-1:0] ans_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign clr_last   = (clr_addr_ff == NODE_BITS'(NODE_DEPTH - 1));
   assign leaf_dup   = (rd_data_ff != '0);
   assign at_root    = (node_ff == NODE_BITS'(1));
   assign root_full  = (rd_data_ff == (NODE_BITS'(1) << VALUE_BITS));
   assign child_full = (rd_data_ff == (NODE_BITS'(1) << level_ff));
   assign at_bottom  = (level_ff == '0);
   assign level_m1   = level_ff - LVL_BITS'(1);
   assign bit_cur    = mask_ff[level_ff];
   assign bit_next   = mask_ff[level_m1];
   assign walk_node  = {node_ff[NODE_BITS-2:0], bit_cur ^ child_full};
   assign ans_next   = ans_ff | (child_full ? (VALUE_BITS'(1) << level_ff) : '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_tuser == MODE_QUERY) ? ST_QRY_ROOT : ST_INS_LEAF;
            end
         end
         ST_INS_LEAF: begin
            state_in = leaf_dup ? ST_IDLE : ST_INS_UP;
         end
         ST_INS_UP: begin
            if (at_root) state_in = ST_IDLE;
         end
         ST_QRY_ROOT: begin
            if (root_full) state_in = rsp_free ? ST_IDLE : ST_QRY_DONE;
            else           state_in = ST_QRY_WALK;
         end
         ST_QRY_WALK: begin
            if (at_bottom) state_in = rsp_free ? ST_IDLE : ST_QRY_DONE;
         end
         ST_QRY_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      rd_en        = 1'b0;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = rd_data_ff + NODE_BITS'(1);
      clr_addr_in  = clr_addr_ff;
      node_in      = node_ff;
      level_in     = level_ff;
      ans_in       = ans_ff;
      mask_in      = mask_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + NODE_BITS'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == MODE_QUERY) begin
                  // fold in the mask and fetch the root count
                  mask_in  = mask_ff ^ req_tdata[VALUE_BITS-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = NODE_BITS'(1);
                  node_in  = NODE_BITS'(1);
                  level_in = LVL_BITS'(VALUE_BITS - 1);
                  ans_in   = '0;
               end else begin
                  // fetch the leaf count for the duplicate test
                  rd_en   = 1'b1;
                  rd_addr = {1'b1, req_tdata[VALUE_BITS-1:0]};
                  node_in = {1'b1, req_tdata[VALUE_BITS-1:0]};
               end
            end
         end
         ST_INS_LEAF, ST_INS_UP: begin
            // bump this node and, below the root, fetch its parent
            if (!(state_ff == ST_INS_LEAF && leaf_dup)) begin
               wr_en   = 1'b1;
               rd_en   = !at_root;
               rd_addr = node_ff >> 1;
               node_in = node_ff >> 1;
            end
         end
         ST_QRY_ROOT: begin
            if (root_full) begin
               res_in = NODE_BITS'(1) << VALUE_BITS;
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = NODE_BITS'(1) << VALUE_BITS;
               end
            end else begin
               // fetch the child the mask bit selects
               rd_en   = 1'b1;
               rd_addr = {node_ff[NODE_BITS-2:0], bit_cur};
            end
         end
         ST_QRY_WALK: begin
            // full child: answer bit set, go to the other branch
            node_in = walk_node;
            ans_in  = ans_next;
            if (at_bottom) begin
               res_in = {1'b0, ans_next};
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {1'b0, ans_next};
               end
            end else begin
               level_in = level_m1;
               rd_en    = 1'b1;
               rd_addr  = {walk_node[NODE_BITS-2:0], bit_next};
            end
         end
         ST_QRY_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      level_ff    <= level_in;
      ans_ff      <= ans_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // count memory write port
   always_ff @(posedge clock) begin
      if (wr_en) node_mem[wr_addr] <= wr_data;
   end

   // count memory read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= node_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_data_ff);

   // a tree update writes back the entry read in the cycle before
   a_rmw_addr: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_CLEAR) |-> (wr_addr == $past(rd_addr)))
      else $error("count write-back address differs from the entry read");

   // a query never modifies the tree
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_ROOT || state_ff == ST_QRY_WALK || state_ff == ST_QRY_DONE)
      |-> !wr_en)
      else $error("tree written during a query");

   // a full-set result carries no low bits
   a_mex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff[VALUE_BITS] || rsp_data_ff[VALUE_BITS-1:0] == '0))
      else $error("mex above the full-set value");

   // a held result is not overwritten by a later query
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_data_ff == $past(rsp_data_ff)))
      else $error("waiting result replaced");

endmodule
